[sv/kri_pkg.sv]
// ----------------------------------------------------------------------------
// kri_pkg
// Shared types and constants for the k-nearest-neighbour row update block.
// ----------------------------------------------------------------------------
package kri_pkg;

  localparam int MODE_W   = 2;
  localparam int ROW_IN_W = 10;
  localparam int SLOT_IN_W = 4;
  localparam int ID_W     = 32;
  localparam int DIST_W   = 32;

  localparam logic [ID_W-1:0]   EMPTY_ID = '1;
  localparam logic [DIST_W-1:0] MAX_DIST = '1;

  // one neighbour slot as stored in the row memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] distance;
    logic              fresh;
  } slot_t;

  localparam slot_t SLOT_RESET = '{id: EMPTY_ID, distance: MAX_DIST, fresh: 1'b0};

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_LOAD   = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

endpackage

[sv/kri_row_mem.sv]
// ----------------------------------------------------------------------------
// kri_row_mem
// Single row-wide synchronous memory, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module kri_row_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int W     = 1040
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/kri_argmax.sv]
// ----------------------------------------------------------------------------
// kri_argmax
// Registered comparison tree giving the greatest distance of a row and the
// lowest slot holding it.
// ----------------------------------------------------------------------------
module kri_argmax #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  logic                                   clk,
  input  logic [SLOTS-1:0][kri_pkg::DIST_W-1:0] distances,
  output logic [kri_pkg::DIST_W-1:0]            worst,
  output logic [IW-1:0]                          worst_idx
);

  import kri_pkg::*;

  localparam int LEVELS = $clog2(SLOTS);
  localparam int P2     = 1 << LEVELS;

  logic [DIST_W-1:0] leaf_d [P2];
  logic [IW-1:0]     leaf_i [P2];

  // padding leaves hold zero and sit above all real slots, so they never win
  for (genvar i = 0; i < P2; i++) begin : g_leaf
    if (i < SLOTS) begin : g_real
      assign leaf_d[i] = distances[i];
      assign leaf_i[i] = IW'(i);
    end else begin : g_pad
      assign leaf_d[i] = '0;
      assign leaf_i[i] = IW'(i);
    end
  end

  if (LEVELS == 0) begin : g_single
    assign worst     = leaf_d[0];
    assign worst_idx = leaf_i[0];
  end else begin : g_tree
    // heap layout: node j has children 2j+1 and 2j+2, leaves follow the nodes
    logic [DIST_W-1:0] node_d [P2-1];
    logic [IW-1:0]     node_i [P2-1];

    for (genvar j = 0; j < P2 - 1; j++) begin : g_node
      logic [DIST_W-1:0] ld, rd;
      logic [IW-1:0]     li, ri;

      if (2 * j + 1 >= P2 - 1) begin : g_from_leaf
        assign ld = leaf_d[2 * j + 1 - (P2 - 1)];
        assign li = leaf_i[2 * j + 1 - (P2 - 1)];
        assign rd = leaf_d[2 * j + 2 - (P2 - 1)];
        assign ri = leaf_i[2 * j + 2 - (P2 - 1)];
      end else begin : g_from_node
        assign ld = node_d[2 * j + 1];
        assign li = node_i[2 * j + 1];
        assign rd = node_d[2 * j + 2];
        assign ri = node_i[2 * j + 2];
      end

      // strict compare keeps the lower slot on a tie
      always_ff @(posedge clk) begin
        if (rd > ld) begin
          node_d[j] <= rd;
          node_i[j] <= ri;
        end else begin
          node_d[j] <= ld;
          node_i[j] <= li;
        end
      end
    end

    assign worst     = node_d[0];
    assign worst_idx = node_i[0];
  end

endmodule

[sv/knn_row_topk_insert.sv]
// ----------------------------------------------------------------------------
// knn_row_topk_insert
// Per-row k-nearest-neighbour list: insert, clear new marks, load and read.
// ----------------------------------------------------------------------------
// After reset the block clears every row of the row memory (in_ready low),
// then takes one item at a time. Each item is accepted while the whole row
// is read from the row-wide memory, passes through the registered worst-slot
// comparison tree, and ends with the row written back and the result
// register loaded. A result waiting in the output register holds back only
// the write-back of the next item.
module knn_row_topk_insert #(
  parameter int ROWS  = 1024,
  parameter int SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kri_pkg::MODE_W-1:0]      mode,
  input  logic [kri_pkg::ROW_IN_W-1:0]    row,
  input  logic [kri_pkg::SLOT_IN_W-1:0]   slot,
  input  logic [kri_pkg::ID_W-1:0]        neighbor_id,
  input  logic [kri_pkg::DIST_W-1:0]      distance,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            accepted,
  output logic [kri_pkg::ID_W-1:0]        slot_id,
  output logic [kri_pkg::DIST_W-1:0]      slot_distance,
  output logic                            slot_new,
  output logic [kri_pkg::DIST_W-1:0]      row_worst
);

  import kri_pkg::*;

  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LEVELS  = $clog2(SLOTS);
  localparam int CNT_W   = (LEVELS > 0) ? $clog2(LEVELS + 1) : 1;
  localparam int ROW_W   = SLOTS * $bits(slot_t);

  state_t state, state_next;
  logic [ROW_AW-1:0] clr_addr;
  logic [CNT_W-1:0]  cnt;

  // captured item
  mode_t             op;
  logic [ROW_AW-1:0] op_row;
  logic              op_row_ok;
  logic [SLOT_AW-1:0] op_slot;
  logic              op_slot_ok;
  logic [ID_W-1:0]   op_id;
  logic [DIST_W-1:0] op_dist;

  logic in_xfer, finish_go;

  logic                   wr_en;
  logic [ROW_AW-1:0]      wr_addr;
  slot_t [SLOTS-1:0]      wr_row;
  slot_t [SLOTS-1:0]      rd_row;
  slot_t [SLOTS-1:0]      upd_row;
  logic                   upd_we;

  logic [SLOTS-1:0][DIST_W-1:0] row_dist;
  logic [DIST_W-1:0]      worst;
  logic [SLOT_AW-1:0]     worst_idx;

  logic              dup;
  logic              res_acc;
  logic [ID_W-1:0]   res_id;
  logic [DIST_W-1:0] res_dist;
  logic              res_new;

  assign in_xfer   = in_valid && in_ready;
  assign finish_go = (state == ST_FINISH) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ROW_AW'(ROWS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) state_next = (LEVELS == 0) ? ST_FINISH : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (cnt == CNT_W'(LEVELS - 1)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish_go) state_next = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + ROW_AW'(1);
      if (state == ST_SEARCH) cnt <= cnt + CNT_W'(1);
      else cnt <= '0;
      if (finish_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op         <= mode_t'(mode);
      op_row     <= ROW_AW'(row);
      op_row_ok  <= 32'(row) < ROWS;
      op_slot    <= SLOT_AW'(slot);
      op_slot_ok <= 32'(slot) < SLOTS;
      op_id      <= neighbor_id;
      op_dist    <= distance;
    end
  end

  kri_row_mem #(
    .DEPTH(ROWS),
    .AW   (ROW_AW),
    .W    (ROW_W)
  ) u_mem (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_row),
    .re   (in_xfer),
    .raddr(ROW_AW'(row)),
    .rdata(rd_row)
  );

  always_comb begin
    for (int s = 0; s < SLOTS; s++) row_dist[s] = rd_row[s].distance;
  end

  kri_argmax #(
    .SLOTS(SLOTS),
    .IW   (SLOT_AW)
  ) u_argmax (
    .clk      (clk),
    .distances(row_dist),
    .worst    (worst),
    .worst_idx(worst_idx)
  );

  // row update and result; read data stays put until the next item
  always_comb begin
    dup = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      if (rd_row[s].id == op_id) dup = 1'b1;
    end
    upd_row  = rd_row;
    upd_we   = 1'b0;
    res_acc  = 1'b0;
    res_id   = '0;
    res_dist = '0;
    res_new  = 1'b0;
    unique case (op)
      MODE_INSERT: begin
        if (!dup && op_dist < worst) begin
          upd_row[worst_idx] = '{id: op_id, distance: op_dist, fresh: 1'b1};
          upd_we  = 1'b1;
          res_acc = 1'b1;
        end
      end
      MODE_CLEAR: begin
        for (int s = 0; s < SLOTS; s++) upd_row[s].fresh = 1'b0;
        upd_we = 1'b1;
      end
      MODE_LOAD: begin
        if (op_slot_ok) begin
          upd_row[op_slot] = '{id: op_id, distance: op_dist, fresh: 1'b1};
          upd_we = 1'b1;
        end
      end
      MODE_READ: begin
        if (op_slot_ok) begin
          res_id   = rd_row[op_slot].id;
          res_dist = rd_row[op_slot].distance;
          res_new  = rd_row[op_slot].fresh;
        end
      end
    endcase
    // out-of-range row leaves the memory alone and reports all zero
    if (!op_row_ok) begin
      upd_we   = 1'b0;
      res_acc  = 1'b0;
      res_id   = '0;
      res_dist = '0;
      res_new  = 1'b0;
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      for (int s = 0; s < SLOTS; s++) wr_row[s] = SLOT_RESET;
    end else begin
      wr_en   = finish_go && upd_we;
      wr_addr = op_row;
      wr_row  = upd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      accepted      <= res_acc;
      slot_id       <= res_id;
      slot_distance <= res_dist;
      slot_new      <= res_new;
      row_worst     <= op_row_ok ? worst : '0;
    end
  end

`ifndef SYNTHESIS
  a_wr_phase: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_CLEAR || state == ST_FINISH))
    else $error("row memory written outside clear pass or write-back");

  a_accept_worst: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (row_worst != '0))
    else $error("insert accepted against a zero worst distance");

  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result appeared without a write-back cycle");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state != ST_IDLE && state != ST_CLEAR))
    else $error("item transfer did not start processing");
`endif

endmodule
